// File: hw/rtl/uiht_pkg.sv
`timescale 1ns / 1ps
package uiht_pkg;

	localparam int unsigned BUCKETS_DEF     = 256;
	localparam int unsigned WAYS_DEF        = 4;
	localparam int unsigned HANDLE_BITS_DEF = 16;

	localparam int unsigned KEY_W    = 24;
	localparam int unsigned HANDLE_W = 16;
	localparam int unsigned COUNT_W  = 11;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [KEY_W-1:0]    key_id;
		logic [HANDLE_W-1:0] user_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] found_handle;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_t;

endpackage

// File: hw/rtl/uiht_ram.sv
`timescale 1ns / 1ps
module uiht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/user_id_hash_table.sv
`timescale 1ns / 1ps
// Keyed table of 24-bit user ids with a record handle per id.
// req channel (valid/ready): req_type insert, lookup or delete, key_id, user_handle.
// rsp channel (valid/ready): status, found_handle, entry_count; one beat per req beat,
// in order. cfg_we/cfg_wdata write miss_handle; the user must write it only while the
// table is idle, which the block does not enforce. Each bucket is one row of the table
// RAM holding WAYS slots (valid, key, handle). The bucket index is computed from key_id
// while the req beat is offered and the row read is launched at acceptance; in S_CMP
// all ways are compared and, once the response register is free, the row is written
// back and the response register loaded. A req beat is taken only in S_IDLE, so each
// request finishes the registered row read, compare and write-back before the next.
// The response register frees the request side: a new req beat is taken while an
// earlier rsp beat waits. If the receiver stalls with a rsp beat pending and the
// next request has finished its compare, that request holds (and req_ready stays
// low) until the pending beat is taken.
// After reset a clearing pass zeroes one row per cycle, all BUCKETS rows; req_ready
// stays low during it. Config writes are taken at any time.
module user_id_hash_table
	import uiht_pkg::*;
#(
	parameter int unsigned BUCKETS     = BUCKETS_DEF,
	parameter int unsigned WAYS        = WAYS_DEF,
	parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  req_t                req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rsp_t                rsp,
	input  logic                cfg_we,
	input  logic [HANDLE_W-1:0] cfg_wdata
);

	localparam int unsigned BW         = $clog2(BUCKETS);
	localparam int unsigned WW         = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned SLOT_TOTAL = BUCKETS * WAYS;
	localparam int unsigned LIVE_W     = $clog2(SLOT_TOTAL + 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic                   vld;
		logic [KEY_W-1:0]       key;
		logic [HANDLE_BITS-1:0] hnd;
	} slot_t;

	typedef slot_t [WAYS-1:0] row_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_CMP
	} state_t;

	state_t                state_q;
	logic [BW-1:0]         clr_q;
	logic [LIVE_W-1:0]     live_q;
	logic [HANDLE_W-1:0]   miss_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [1:0]            type_q;
	logic [KEY_W-1:0]      key_q;
	logic [HANDLE_W-1:0]   hnd_q;
	logic [BW-1:0]         bkt_q;

	// hashpjw on three bytes: b0*256 + b1*16 + b2, reduced per byte by constant tables
	logic [BW-1:0] tab0 [256];
	logic [BW-1:0] tab1 [256];
	logic [BW-1:0] tab2 [256];

	for (genvar i = 0; i < 256; i++) begin : g_tab
		localparam int unsigned M0 = (i * 256) % BUCKETS;
		localparam int unsigned M1 = (i * 16) % BUCKETS;
		localparam int unsigned M2 = i % BUCKETS;
		assign tab0[i] = BW'(M0);
		assign tab1[i] = BW'(M1);
		assign tab2[i] = BW'(M2);
	end

	logic [BW+1:0] hsum;
	logic [BW-1:0] bkt;

	always_comb begin
		hsum = (BW+2)'(tab0[req.key_id[23:16]]) + (BW+2)'(tab1[req.key_id[15:8]])
			+ (BW+2)'(tab2[req.key_id[7:0]]);
		if (hsum >= (BW+2)'(2 * BUCKETS)) begin
			bkt = BW'(hsum - (BW+2)'(2 * BUCKETS));
		end else if (hsum >= (BW+2)'(BUCKETS)) begin
			bkt = BW'(hsum - (BW+2)'(BUCKETS));
		end else begin
			bkt = BW'(hsum);
		end
	end

	logic   accept;
	logic   fire;
	row_t   row_rd;
	row_t   row_wr;
	logic   ram_we;
	logic [BW-1:0] ram_waddr;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign fire      = (state_q == S_CMP) && (!rsp_valid_q || rsp_ready);

	uiht_ram #(
		.WIDTH($bits(row_t)),
		.DEPTH(BUCKETS)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(row_wr),
		.re   (accept),
		.raddr(bkt),
		.rdata(row_rd)
	);

	// way match and lowest free way of the row just read
	logic          hit;
	logic [WW-1:0] hit_w;
	logic          has_free;
	logic [WW-1:0] free_w;

	always_comb begin
		hit      = 1'b0;
		hit_w    = '0;
		has_free = 1'b0;
		free_w   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_rd[w].vld && row_rd[w].key == key_q) begin
				hit   = 1'b1;
				hit_w = WW'(w);
			end
			if (!row_rd[w].vld) begin
				has_free = 1'b1;
				free_w   = WW'(w);
			end
		end
	end

	logic [1:0]          st_n;
	logic [HANDLE_W-1:0] ans_n;
	logic [LIVE_W-1:0]   live_n;
	row_t                row_n;
	logic                row_mod;

	always_comb begin
		st_n    = ST_OK;
		ans_n   = miss_q;
		live_n  = live_q;
		row_n   = row_rd;
		row_mod = 1'b0;
		case (type_q)
			REQ_INSERT: begin
				if (hit) begin
					st_n = ST_DUP;
				end else if (!has_free) begin
					st_n = ST_FULL;
				end else begin
					row_n[free_w].vld = 1'b1;
					row_n[free_w].key = key_q;
					row_n[free_w].hnd = HANDLE_BITS'(hnd_q);
					row_mod = 1'b1;
					live_n  = live_q + LIVE_W'(1);
				end
			end
			REQ_LOOKUP: begin
				if (hit) begin
					ans_n = HANDLE_W'(row_rd[hit_w].hnd);
				end else begin
					st_n = ST_MISS;
				end
			end
			REQ_DELETE: begin
				if (hit) begin
					row_n[hit_w].vld = 1'b0;
					row_mod = 1'b1;
					if (live_q != '0) begin
						live_n = live_q - LIVE_W'(1);
					end
				end else begin
					st_n = ST_MISS;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			row_wr    = '0;
		end else begin
			ram_we    = fire && row_mod;
			ram_waddr = bkt_q;
			row_wr    = row_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			key_q  <= req.key_id;
			hnd_q  <= req.user_handle;
			bkt_q  <= bkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= '0;
		end else if (cfg_we) begin
			miss_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			live_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !fire) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (fire) begin
						live_q             <= live_n;
						rsp_valid_q        <= 1'b1;
						rsp_q.status       <= st_n;
						rsp_q.found_handle <= ans_n;
						rsp_q.entry_count  <= (32'(live_n) > 32'(COUNT_MAX)) ?
							COUNT_MAX : COUNT_W'(live_n);
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: dv/user_id_hash_table_test.sv
`timescale 1ns / 1ps
module user_id_hash_table_test;
	import uiht_pkg::*;

	localparam logic [1:0] REQ_NOP = 2'd3;	// unused request code, must be a no-op
	localparam int unsigned SLOT_COUNT = BUCKETS_DEF * WAYS_DEF;
	localparam int ITEMS_PER_PHASE = 282;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                clk;
	logic                arst_n;
	logic                req_valid = 1'b0;
	logic                req_ready;
	req_t                req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	rsp_t                rsp;
	logic                cfg_we = 1'b0;
	logic [HANDLE_W-1:0] cfg_wdata = '0;

	// shadow copy of the table
	bit                  slot_valid [SLOT_COUNT];
	logic [KEY_W-1:0]    slot_key [SLOT_COUNT];
	logic [HANDLE_W-1:0] slot_handle [SLOT_COUNT];
	int unsigned         live_count = 0;
	logic [HANDLE_W-1:0] miss_handle_cfg = '0;

	req_t req_backlog_q [$];
	rsp_t pending_rsp_q [$];
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   mismatch_count = 0;
	int   quiet_cycles = 0;

	user_id_hash_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic rsp_t predict_table_op(input req_t r);
		int unsigned base;
		int          hit;
		int          free_way;
		rsp_t        o;
		// hashpjw on three bytes: no fold, b0 drops out of the low 8 bits
		base = ((int'(r.key_id[23:16]) << 8) + (int'(r.key_id[15:8]) << 4)
			+ int'(r.key_id[7:0])) % BUCKETS_DEF * WAYS_DEF;
		hit = -1;
		free_way = -1;
		for (int w = 0; w < WAYS_DEF; w++) begin
			if (slot_valid[base + w]) begin
				if (hit < 0 && slot_key[base + w] == r.key_id)
					hit = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		o.status = ST_OK;
		o.found_handle = miss_handle_cfg;
		case (r.req_type)
		REQ_INSERT: begin
			if (hit >= 0) begin
				o.status = ST_DUP;
			end else if (free_way < 0) begin
				o.status = ST_FULL;
			end else begin
				slot_valid[base + free_way] = 1'b1;
				slot_key[base + free_way] = r.key_id;
				slot_handle[base + free_way] = r.user_handle;
				live_count++;
			end
		end
		REQ_LOOKUP: begin
			if (hit >= 0)
				o.found_handle = slot_handle[base + hit];
			else
				o.status = ST_MISS;
		end
		REQ_DELETE: begin
			if (hit >= 0) begin
				slot_valid[base + hit] = 1'b0;
				if (live_count > 0)
					live_count--;
			end else begin
				o.status = ST_MISS;
			end
		end
		default: ;
		endcase
		o.entry_count = (live_count > 2047) ? 11'd2047 : live_count[COUNT_W-1:0];
		return o;
	endfunction

	task automatic push_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input logic [HANDLE_W-1:0] hnd);
		req_t r;
		r.req_type = op;
		r.key_id = key;
		r.user_handle = hnd;
		req_backlog_q.push_back(r);
	endtask

	// table must be idle here; every request gives a beat, so an empty queue means idle
	task automatic write_miss_handle(input logic [HANDLE_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		miss_handle_cfg = v;
	endtask

	task automatic drain_table();
		@(negedge clk);
		while (req_backlog_q.size() != 0 || req_valid || pending_rsp_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready)
				pending_rsp_q.push_back(predict_table_op(req));
			if (!req_valid || req_ready) begin
				if (req_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= req_backlog_q.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp_q.size() == 0) begin
					$error("response beat with no request outstanding");
					mismatch_count++;
				end else begin
					exp_rsp = pending_rsp_q.pop_front();
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.found_handle !== exp_rsp.found_handle) begin
						$error("found_handle: expected 0x%04h, got 0x%04h",
							exp_rsp.found_handle, rsp.found_handle);
						mismatch_count++;
					end
					if (rsp.entry_count !== exp_rsp.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							exp_rsp.entry_count, rsp.entry_count);
						mismatch_count++;
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("user_id_hash_table regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [15:0]      hot_low [6];
		logic [7:0]       hot_top [8];
		logic [KEY_W-1:0] key;
		logic [1:0]       op;
		int               pick;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		write_miss_handle(16'hFFFF);
		push_item(REQ_INSERT, 24'h000000, 16'h0000);
		push_item(REQ_INSERT, 24'hFFFFFF, 16'hFFFF);
		push_item(REQ_INSERT, 24'h000000, 16'h1234);	// duplicate
		push_item(REQ_LOOKUP, 24'h000000, 16'h0000);
		push_item(REQ_LOOKUP, 24'hFFFFFF, 16'h0000);
		push_item(REQ_LOOKUP, 24'h123456, 16'h0000);	// miss
		// same low 16 bits -> same bucket as 24'h000000, fill its remaining ways
		push_item(REQ_INSERT, 24'h010000, 16'h0101);
		push_item(REQ_INSERT, 24'h020000, 16'h0202);
		push_item(REQ_INSERT, 24'h030000, 16'h0303);
		push_item(REQ_INSERT, 24'h040000, 16'h0404);	// bucket full
		push_item(REQ_DELETE, 24'h020000, 16'h0000);
		push_item(REQ_DELETE, 24'h020000, 16'h0000);	// delete miss
		push_item(REQ_INSERT, 24'h040000, 16'h0404);	// reuses the freed way
		push_item(REQ_LOOKUP, 24'h040000, 16'h0000);
		push_item(REQ_LOOKUP, 24'h030000, 16'h0000);
		push_item(REQ_NOP,    24'hABCDEF, 16'h5555);
		push_item(REQ_DELETE, 24'hFFFFFF, 16'h0000);
		push_item(REQ_LOOKUP, 24'hFFFFFF, 16'h0000);
		// different middle/low bytes hashing to the same bucket
		push_item(REQ_INSERT, 24'h000100, 16'hAAAA);
		push_item(REQ_INSERT, 24'h000010, 16'h5555);
		push_item(REQ_LOOKUP, 24'h000010, 16'h0000);
		push_item(REQ_LOOKUP, 24'h000100, 16'h0000);
		drain_table();

		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
				write_miss_handle(16'h0000);
			end
			1: begin
				send_idle_pct = 86;
				recv_stall_pct = 0;
				write_miss_handle(16'($urandom_range(0, 16'hFFFF)));
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 86;
				write_miss_handle(16'($urandom_range(0, 16'hFFFF)));
			end
			default: begin
				send_idle_pct = 32;
				recv_stall_pct = 32;
				write_miss_handle(16'hFFFF);
			end
			endcase
			// a few crowded buckets so that hits, duplicates and full buckets are common
			for (int k = 0; k < 6; k++)
				hot_low[k] = 16'($urandom_range(0, 16'hFFFF));
			for (int k = 0; k < 8; k++)
				hot_top[k] = 8'($urandom_range(0, 255));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 80)
					key = {hot_top[$urandom_range(7)], hot_low[$urandom_range(5)]};
				else
					key = KEY_W'($urandom_range(0, 24'hFFFFFF));
				pick = $urandom_range(99);
				if (pick < 40)
					op = REQ_INSERT;
				else if (pick < 70)
					op = REQ_LOOKUP;
				else if (pick < 95)
					op = REQ_DELETE;
				else
					op = REQ_NOP;
				push_item(op, key, HANDLE_W'($urandom_range(0, 16'hFFFF)));
			end
			drain_table();
		end

		if (pending_rsp_q.size() != 0) begin
			$error("%0d responses never arrived", pending_rsp_q.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("user_id_hash_table regression: pass");
		else
			$display("user_id_hash_table regression: fail");
		$finish;
	end

endmodule
